// ===== sv/fubs_pkg.sv =====
// Shared types, constants and the double compare for the upper bound search.
package fubs_pkg;
  localparam int TableDepth = 1024;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int PosW       = $clog2(TableDepth + 1);
  localparam int NumSteps   = PosW;
  localparam int DataW      = 64;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic [2:0] ADDR_TABLE_SIZE = 3'd0;

  localparam logic [DataW-1:0] AbsMask = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DataW-1:0] ExpAll1 = 64'h7FF0_0000_0000_0000;

  typedef struct packed {
    logic             vld;
    logic             wr;
    logic [AddrW-1:0] idx;
    logic [DataW-1:0] key;
    logic [PosW-1:0]  first;
    logic [PosW-1:0]  count;
  } item_t;

  function automatic logic [DataW-1:0] order_key(input logic [DataW-1:0] x);
    order_key = x[DataW-1] ? ~x : (x | {1'b1, {(DataW-1){1'b0}}});
  endfunction

  // entry <= key, or unordered
  function automatic logic ule_bits(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    logic nan_a;
    logic nan_b;
    logic zeros;
    nan_a = (a & AbsMask) > ExpAll1;
    nan_b = (b & AbsMask) > ExpAll1;
    zeros = ((a & AbsMask) == '0) && ((b & AbsMask) == '0);
    ule_bits = nan_a || nan_b || zeros || (order_key(a) <= order_key(b));
  endfunction
endpackage

// ===== sv/fubs_step.sv =====
// One search iteration: table copy read, then compare and narrow the range.
module fubs_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  fubs_pkg::item_t item_i,
  output fubs_pkg::item_t item_o
);
  import fubs_pkg::*;

  logic [DataW-1:0] mem [TableDepth];
  item_t            a_q;
  logic [PosW-1:0]  it_d, it_q;
  logic [DataW-1:0] rd_q;
  item_t            b_d, b_q;
  logic [PosW-1:0]  step;

  assign it_d = item_i.first + (item_i.count >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (item_i.vld && item_i.wr) begin
        mem[item_i.idx] <= item_i.key;
      end
      rd_q <= mem[it_d[AddrW-1:0]];
      it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else if (en_i) begin
      a_q <= item_i;
      b_q <= b_d;
    end
  end

  always_comb begin
    b_d  = a_q;
    step = a_q.count >> 1;
    if (a_q.count != '0) begin
      if (ule_bits(rd_q, a_q.key)) begin
        b_d.first = it_q + PosW'(1);
        b_d.count = a_q.count - step - PosW'(1);
      end else begin
        b_d.count = step;
      end
    end
  end

  assign item_o = b_q;
endmodule

// ===== sv/float_upper_bound_search_core.sv =====
// Upper bound search over a sorted table of doubles.
// Usage:
//   Input channel (in_valid_i/in_ready_o): req_type_i selects a write of
//   value_i to entry entry_index_i, or a search for key value_i.
//   Output channel (out_valid_o/out_ready_i): one position_o per search,
//   the index of the first entry above the key within table_size entries.
//   Writes give no result.
//   APB register 0 (address 0): table_size, 11 bits; searches saturate it to 1024.
// Timing:
//   Eleven search steps, each a registered table read and a registered
//   compare, then an output register.
//   One item enters per cycle while no stall holds the pipeline; each step
//   keeps its own table copy, written in item order as a write item passes.
// Reset clears all valid bits and table_size; table contents stay undefined
//   until written.
// Stall: while a result waits on out_ready_i the whole pipeline holds and
//   in_ready_o is low.
module float_upper_bound_search_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [fubs_pkg::AddrW-1:0]  entry_index_i,
  input  logic [fubs_pkg::DataW-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fubs_pkg::PosW-1:0]   position_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fubs_pkg::*;

  logic            en;
  logic [10:0]     size_q;
  logic [PosW-1:0] n_eff;
  item_t           chain [NumSteps+1];
  logic            out_valid_q;
  logic [PosW-1:0] pos_q;

  assign pready = 1'b1;
  assign prdata = {21'd0, size_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
    end else if (psel && penable && pwrite && paddr == ADDR_TABLE_SIZE) begin
      size_q <= pwdata[10:0];
    end
  end

  assign n_eff = (32'(size_q) > TableDepth) ? PosW'(TableDepth) : PosW'(size_q);

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    chain[0].vld   = in_valid_i;
    chain[0].wr    = (req_type_i == REQ_WRITE);
    chain[0].idx   = entry_index_i;
    chain[0].key   = value_i;
    chain[0].first = '0;
    chain[0].count = (req_type_i == REQ_SEARCH) ? n_eff : '0;
  end

  for (genvar g = 0; g < NumSteps; g++) begin : g_step
    fubs_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .item_i (chain[g]),
      .item_o (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain[NumSteps].vld && !chain[NumSteps].wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q <= chain[NumSteps].first;
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;
endmodule

// ===== sv/fubs_checker.sv =====
// Port-level checks for the upper bound search core, with its bind.
module fubs_port_props (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [fubs_pkg::PosW-1:0] position_o,
  input logic                      pready
);
  import fubs_pkg::*;

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i)) else $error("input blocked without stall");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(position_o)))
    else $error("result dropped or changed under stall");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(position_o) <= TableDepth)) else $error("position beyond depth");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready) else $error("pready low");
endmodule

bind float_upper_bound_search_core fubs_port_props u_fubs_port_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .position_o  (position_o),
  .pready      (pready)
);

// ===== bench/fubs_checker.sv =====
// Scoreboard for the upper bound search core: tracks the table and size, predicts positions.
`timescale 1ns / 100ps
module fubs_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic                       req_type_i,
  input  logic [fubs_pkg::AddrW-1:0] entry_index_i,
  input  logic [fubs_pkg::DataW-1:0] value_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [fubs_pkg::PosW-1:0]  position_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [2:0]                 paddr_i,
  input  logic [31:0]                pwdata_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         searches_o,
  output int                         writes_o
);
  import fubs_pkg::*;

  logic [DataW-1:0] entry_mem [TableDepth];
  logic [PosW-1:0]  size_q;
  logic [PosW-1:0]  position_q [$];

  function automatic logic [DataW-1:0] to_order(input logic [DataW-1:0] x);
    return x[63] ? ~x : {1'b1, x[62:0]};
  endfunction

  function automatic logic not_above(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    if (a[62:0] > 63'h7FF0_0000_0000_0000 || b[62:0] > 63'h7FF0_0000_0000_0000) return 1'b1;
    if (a[62:0] == '0 && b[62:0] == '0) return 1'b1;
    return to_order(a) <= to_order(b);
  endfunction

  function automatic logic [PosW-1:0] predict_pos(input logic [DataW-1:0] key);
    int lo;
    int cnt;
    int half;
    lo  = 0;
    cnt = (size_q > TableDepth) ? TableDepth : size_q;
    while (cnt > 0) begin
      half = cnt / 2;
      if (not_above(entry_mem[lo + half], key)) begin
        lo  = lo + half + 1;
        cnt = cnt - half - 1;
      end else begin
        cnt = half;
      end
    end
    return lo[PosW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [PosW-1:0] want;
    if (!rst_ni) begin
      size_q = '0;
      position_q.delete();
      fail_count_o = 0;
      searches_o = 0;
      writes_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (position_q.size() == 0) begin
          $error("position: no result expected, got %0d", position_i);
          fail_count_o++;
        end else begin
          want = position_q.pop_front();
          if (position_i !== want) begin
            $error("position: expected %0d, got %0d", want, position_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (req_type_i == REQ_WRITE) begin
          entry_mem[entry_index_i] = value_i;
          writes_o++;
        end else begin
          position_q.insert(position_q.size(), predict_pos(value_i));
          searches_o++;
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ADDR_TABLE_SIZE)
        size_q = pwdata_i[PosW-1:0];
    end
    pending_o = position_q.size();
  end
endmodule

// ===== bench/float_upper_bound_search_core_tb.sv =====
// Testbench top for the upper bound search core: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module float_upper_bound_search_core_tb;
  import fubs_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_ready;
  logic             req_type;
  logic [AddrW-1:0] entry_index;
  logic [DataW-1:0] value;
  logic             out_valid;
  logic             out_ready;
  logic [PosW-1:0]  position;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  int fail_count;
  int pending;
  int searches;
  int writes;
  int gap_pct;
  int stall_pct;
  int hold_req;
  int hold_ack;
  int hold_left;
  int cycles;

  logic [DataW-1:0] sorted_img [TableDepth];
  logic [DataW-1:0] specials [10];

  float_upper_bound_search_core u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(req_type), .entry_index_i(entry_index), .value_i(value),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .position_o(position),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  fubs_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .req_type_i(req_type), .entry_index_i(entry_index), .value_i(value),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .position_i(position),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending),
    .searches_o(searches), .writes_o(writes)
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("** float_upper_bound_search_core: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold on request
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic logic [DataW-1:0] from_order(input logic [DataW-1:0] k);
    return k[63] ? {1'b0, k[62:0]} : ~k;
  endfunction

  function automatic logic [DataW-1:0] to_order(input logic [DataW-1:0] x);
    return x[63] ? ~x : {1'b1, x[62:0]};
  endfunction

  task automatic send(input logic kind, input logic [AddrW-1:0] idx, input logic [DataW-1:0] v);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    req_type    <= kind;
    entry_index <= idx;
    value       <= v;
    if (kind == REQ_WRITE) sorted_img[idx] = v;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
  endtask

  task automatic set_size(input logic [31:0] n);
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (30) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TABLE_SIZE;
    pwdata  <= n;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_table(input int n);
    logic [DataW-1:0] k;
    logic [DataW-1:0] stride;
    k = {$urandom, $urandom} >> $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      stride = ($urandom_range(0, 9) == 0) ? '0 : {$urandom, $urandom} >> $urandom_range(12, 63);
      if (k + stride < k) stride = '0;
      k = k + stride;
      send(REQ_WRITE, i[AddrW-1:0], from_order(k));
    end
  endtask

  task automatic search_burst(input int n, input int count);
    logic [DataW-1:0] key;
    logic [AddrW-1:0] idx;
    for (int q = 0; q < count; q++) begin
      idx = (n > 0) ? AddrW'($urandom_range(0, n - 1)) : '0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: key = (n > 0) ? from_order(to_order(sorted_img[idx])
                                               + 64'($urandom_range(0, 4)) - 64'd2)
                                  : {$urandom, $urandom};
        4, 5:    key = (n > 0) ? sorted_img[idx] : specials[$urandom_range(0, 9)];
        6:       key = {$urandom, $urandom};
        7:       key = specials[$urandom_range(0, 9)];
        default: key = (n > 0) ? sorted_img[idx] ^ 64'h8000_0000_0000_0000 : {$urandom, $urandom};
      endcase
      if ($urandom_range(0, 11) == 0) begin
        idx = AddrW'($urandom_range(0, TableDepth - 1));
        send(REQ_WRITE, idx, (n < TableDepth && idx < n) ? sorted_img[idx] : {$urandom, $urandom});
      end
      send(REQ_SEARCH, AddrW'($urandom_range(0, TableDepth - 1)), key);
    end
  endtask

  initial begin
    int sizes [12] = '{0, 1, 2, 3, 5, 16, 33, 100, 1024, 2047, 300, 64};
    int n;
    specials = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                 64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                 64'h3FF0_0000_0000_0000};
    rst_ni = 1'b0; cycles = 0;
    in_valid = 1'b0; req_type = 1'b0; entry_index = '0; value = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    out_ready = 1'b0; gap_pct = 0; stall_pct = 0; hold_req = 0; hold_ack = 0; hold_left = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero size, then a table of signed zeros, infinities, minus one and a NaN
    send(REQ_SEARCH, 10'h3FF, specials[4]);
    send(REQ_SEARCH, '0, specials[0]);
    send(REQ_SEARCH, '0, specials[5]);
    send(REQ_WRITE, 10'd0, specials[3]);
    send(REQ_WRITE, 10'd1, 64'hBFF0_0000_0000_0000);
    send(REQ_WRITE, 10'd2, specials[1]);
    send(REQ_WRITE, 10'd3, specials[0]);
    send(REQ_WRITE, 10'd4, specials[4]);
    send(REQ_WRITE, 10'd5, specials[2]);
    send(REQ_WRITE, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF);
    set_size(6);
    foreach (specials[s]) send(REQ_SEARCH, '0, specials[s]);
    send(REQ_SEARCH, '0, 64'hBFF0_0000_0000_0000);

    for (int p = 0; p < 12; p++) begin
      gap_pct   = (p % 4 == 1) ? 69 : (p % 4 == 3) ? 38 : 0;
      stall_pct = (p % 4 == 2) ? 69 : (p % 4 == 3) ? 38 : 0;
      n = (sizes[p] > TableDepth) ? TableDepth : sizes[p];
      set_size(sizes[p]);
      if (sizes[p] <= 100 || sizes[p] == TableDepth) load_table(n);
      if (sizes[p] == 100) hold_req <= hold_req + 1;
      search_burst(n, 40);
    end

    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
    $display("Covered %0d searches and %0d table writes over table sizes 0 to 2047,", searches, writes);
    $display("with sender gaps, receiver stalls and a long output hold.");
    if (fail_count == 0) begin
      $display("** float_upper_bound_search_core: PASSED **");
    end else begin
      $display("** float_upper_bound_search_core: FAILED **");
    end
    $finish;
  end
endmodule
